/* src/ctpd_pkg.sv */
// Package for the color table packet decoder: codes, summary and control
// structs, and the CRC-16 byte update used by the parser and the testbench.
// No dependencies.
package ctpd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int NAME_LEN_W = 6;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [NAME_LEN_W-1:0] name_len_type;

   localparam csr_index_type REG_MAGIC_FIRST = 3'd0;
   localparam csr_index_type REG_MAGIC_SECOND = 3'd1;
   localparam csr_index_type REG_PROTO_VERSION = 3'd2;
   localparam csr_index_type REG_LIGHT_MASK = 3'd3;
   localparam csr_index_type REG_NAME_TAG = 3'd4;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_COLOR = 2'd1;
   localparam logic [1:0] KIND_NAME = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ST_BAD_VERSION = 3'd2;
   localparam logic [2:0] ST_BAD_CRC = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;
   localparam logic [2:0] ST_BAD_TLV = 3'd5;

   localparam int POS_MAGIC0 = 0;
   localparam int POS_MAGIC1 = 1;
   localparam int POS_VERSION = 2;
   localparam int POS_FLAGS = 3;
   localparam int POS_COUNT = 4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_VALUE
   } phase_type;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_FIN,
      EM_COLOR_RD,
      EM_COLOR_OUT,
      EM_NAME_RD,
      EM_NAME_OUT
   } emit_state_type;

   typedef struct packed {
      logic [2:0] status;
      logic light;
      logic [7:0] color_count;
      logic [15:0] packet_crc;
      name_len_type name_length;
   } summary_type;

   typedef struct packed {
      logic hold;
      logic clear;
   } ctrl_type;

   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

/* src/ctpd_if.sv */
// Handshake interfaces for the decoder's byte input and result output.
// Valid/ready channels with source and sink modports; no dependencies.
interface ctpd_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface ctpd_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [2:0] status;
   logic light;
   logic [7:0] color_count;
   logic [15:0] packet_crc;
   logic [3:0] role;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] name_char;
   logic run_end;

   modport source (output valid, output kind, output status, output light,
                   output color_count, output packet_crc, output role, output red,
                   output green, output blue, output name_char, output run_end,
                   input ready);
   modport sink (input valid, input kind, input status, input light,
                 input color_count, input packet_crc, input role, input red,
                 input green, input blue, input name_char, input run_end,
                 output ready);
endinterface

/* src/ctpd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ctpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ctpd_parser.sv */
// Byte parser: configuration registers, two-byte CRC delay, header checks,
// color and record walking with writes into the color and name RAMs.
// Depends on ctpd_pkg and ctpd_if.
module ctpd_parser #(
   parameter int MAX_PACKET = 256,
   parameter int HEADER_BYTES = 5,
   parameter int ROLES = 14,
   parameter int MAX_NAME = 32,
   localparam int CA_W = (ROLES > 1) ? $clog2(ROLES) : 1,
   localparam int NA_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  ctpd_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata,
   ctpd_req_if.sink               req_bus,
   input  ctpd_pkg::ctrl_type     ctrl,
   output logic                   pkt_done,
   output ctpd_pkg::summary_type  summary,
   output logic                   color_wr_en,
   output logic [CA_W-1:0]        color_wr_addr,
   output logic [23:0]            color_wr_data,
   output logic                   name_wr_en,
   output logic [NA_W-1:0]        name_wr_addr,
   output logic [7:0]             name_wr_data
);
   import ctpd_pkg::*;

   localparam int POS_W = $clog2(MAX_PACKET + 1);
   localparam int CMP_W = $clog2(MAX_PACKET + HEADER_BYTES + 767);
   localparam int NL_W = $clog2(MAX_NAME + 1);

   logic [7:0] magic_first_ff, magic_second_ff, proto_version_ff, light_mask_ff, name_tag_ff;

   logic [7:0] d0_ff, d0_in, d1_ff, d1_in;
   logic [1:0] fill_ff, fill_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic magic_bad_ff, magic_bad_in, version_bad_ff, version_bad_in;
   logic light_ff, light_in;
   logic [7:0] declared_ff, declared_in;
   logic [1:0] comp_ff, comp_in;
   logic [7:0] cidx_ff, cidx_in;
   logic [7:0] red_ff, red_in, green_ff, green_in;
   phase_type phase_ff, phase_in;
   logic is_name_ff, is_name_in;
   logic [7:0] left_ff, left_in;
   logic [NL_W-1:0] nlen_ff, nlen_in;
   logic [7:0] nwi_ff, nwi_in;

   logic accept, body_en, in_colors;
   logic [7:0] bb;
   logic [CMP_W-1:0] colors_end, pos_wide;
   logic [POS_W:0] total;
   logic short_pkt;
   logic [15:0] expected;
   logic [2:0] status;

   assign req_bus.ready = !ctrl.hold;
   assign accept = req_bus.valid && !ctrl.hold;
   assign pkt_done = accept && req_bus.end_of_packet;
   assign bb = d0_ff;
   assign body_en = accept && (fill_ff == 2'd2) && (pos_ff < POS_W'(MAX_PACKET));
   assign colors_end = CMP_W'(HEADER_BYTES) + (CMP_W'(declared_ff) << 1) + CMP_W'(declared_ff);
   assign pos_wide = CMP_W'(pos_ff);
   assign in_colors = (pos_ff >= POS_W'(HEADER_BYTES)) && (pos_wide < colors_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff <= 8'd0;
         magic_second_ff <= 8'd0;
         proto_version_ff <= 8'd1;
         light_mask_ff <= 8'd1;
         name_tag_ff <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAGIC_FIRST: magic_first_ff <= csr_wdata;
            REG_MAGIC_SECOND: magic_second_ff <= csr_wdata;
            REG_PROTO_VERSION: proto_version_ff <= csr_wdata;
            REG_LIGHT_MASK: light_mask_ff <= csr_wdata;
            REG_NAME_TAG: name_tag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      d0_in = d0_ff;
      d1_in = d1_ff;
      fill_in = fill_ff;
      pos_in = pos_ff;
      crc_in = crc_ff;
      magic_bad_in = magic_bad_ff;
      version_bad_in = version_bad_ff;
      light_in = light_ff;
      declared_in = declared_ff;
      comp_in = comp_ff;
      cidx_in = cidx_ff;
      red_in = red_ff;
      green_in = green_ff;
      phase_in = phase_ff;
      is_name_in = is_name_ff;
      left_in = left_ff;
      nlen_in = nlen_ff;
      nwi_in = nwi_ff;
      color_wr_en = 1'b0;
      name_wr_en = 1'b0;

      if (accept) begin
         if (fill_ff == 2'd2) begin
            d0_in = d1_ff;
            d1_in = req_bus.data_byte;
         end else if (fill_ff == 2'd0) begin
            d0_in = req_bus.data_byte;
            fill_in = 2'd1;
         end else begin
            d1_in = req_bus.data_byte;
            fill_in = 2'd2;
         end
      end

      if (body_en) begin
         pos_in = pos_ff + POS_W'(1);
         crc_in = crc16_byte(crc_ff, bb);
         if (pos_ff == POS_W'(POS_MAGIC0)) begin
            magic_bad_in = magic_bad_ff || (bb != magic_first_ff);
         end
         if (pos_ff == POS_W'(POS_MAGIC1)) begin
            magic_bad_in = magic_bad_ff || (bb != magic_second_ff);
         end
         if (pos_ff == POS_W'(POS_VERSION)) begin
            version_bad_in = (bb != proto_version_ff);
         end
         if (pos_ff == POS_W'(POS_FLAGS)) begin
            light_in = (bb & light_mask_ff) != 8'd0;
         end
         if (pos_ff == POS_W'(POS_COUNT)) begin
            declared_in = bb;
         end
         if (pos_ff >= POS_W'(HEADER_BYTES)) begin
            if (in_colors) begin
               case (comp_ff)
                  2'd0: begin
                     red_in = bb;
                     comp_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = bb;
                     comp_in = 2'd2;
                  end
                  default: begin
                     color_wr_en = cidx_ff < 8'(ROLES);
                     comp_in = 2'd0;
                     cidx_in = cidx_ff + 8'd1;
                  end
               endcase
            end else begin
               case (phase_ff)
                  PH_TAG: begin
                     is_name_in = (bb == name_tag_ff);
                     phase_in = PH_LEN;
                  end
                  PH_LEN: begin
                     if (is_name_ff) begin
                        nlen_in = '0;
                        nwi_in = 8'd0;
                     end
                     left_in = bb;
                     phase_in = (bb == 8'd0) ? PH_TAG : PH_VALUE;
                  end
                  default: begin
                     if (is_name_ff) begin
                        if (nwi_ff < 8'(MAX_NAME)) begin
                           name_wr_en = 1'b1;
                           nlen_in = NL_W'(nwi_ff + 8'd1);
                        end
                        if (nwi_ff != 8'hFF) begin
                           nwi_in = nwi_ff + 8'd1;
                        end
                     end
                     left_in = left_ff - 8'd1;
                     if (left_ff == 8'd1) begin
                        phase_in = PH_TAG;
                     end
                  end
               endcase
            end
         end
      end

      if (ctrl.clear) begin
         fill_in = 2'd0;
         pos_in = '0;
         crc_in = CRC_INIT;
         magic_bad_in = 1'b0;
         version_bad_in = 1'b0;
         light_in = 1'b0;
         declared_in = 8'd0;
         comp_in = 2'd0;
         cidx_in = 8'd0;
         phase_in = PH_TAG;
         is_name_in = 1'b0;
         left_in = 8'd0;
         nlen_in = '0;
         nwi_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff <= d0_in;
      d1_ff <= d1_in;
      red_ff <= red_in;
      green_ff <= green_in;
      if (reset) begin
         fill_ff <= 2'd0;
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
         magic_bad_ff <= 1'b0;
         version_bad_ff <= 1'b0;
         light_ff <= 1'b0;
         declared_ff <= 8'd0;
         comp_ff <= 2'd0;
         cidx_ff <= 8'd0;
         phase_ff <= PH_TAG;
         is_name_ff <= 1'b0;
         left_ff <= 8'd0;
         nlen_ff <= '0;
         nwi_ff <= 8'd0;
      end else begin
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         magic_bad_ff <= magic_bad_in;
         version_bad_ff <= version_bad_in;
         light_ff <= light_in;
         declared_ff <= declared_in;
         comp_ff <= comp_in;
         cidx_ff <= cidx_in;
         phase_ff <= phase_in;
         is_name_ff <= is_name_in;
         left_ff <= left_in;
         nlen_ff <= nlen_in;
         nwi_ff <= nwi_in;
      end
   end

   assign color_wr_addr = CA_W'(cidx_ff);
   assign color_wr_data = {red_ff, green_ff, bb};
   assign name_wr_addr = NA_W'(nwi_ff);
   assign name_wr_data = bb;

   assign total = (POS_W + 1)'(pos_ff) + (POS_W + 1)'(fill_ff);
   assign short_pkt = (fill_ff != 2'd2) || (total > (POS_W + 1)'(MAX_PACKET))
                      || (pos_ff < POS_W'(HEADER_BYTES));
   assign expected = {d1_ff, d0_ff};

   always_comb begin
      if (short_pkt) begin
         status = ST_TRUNCATED;
      end else if (magic_bad_ff) begin
         status = ST_BAD_MAGIC;
      end else if (version_bad_ff) begin
         status = ST_BAD_VERSION;
      end else if (crc_ff != expected) begin
         status = ST_BAD_CRC;
      end else if (colors_end > pos_wide) begin
         status = ST_TRUNCATED;
      end else if (phase_ff != PH_TAG) begin
         status = ST_BAD_TLV;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      summary.status = status;
      summary.light = (status == ST_OK) ? light_ff : 1'b0;
      summary.color_count = (status == ST_OK) ? declared_ff : 8'd0;
      summary.packet_crc = (status == ST_OK) ? expected : 16'd0;
      summary.name_length = name_len_type'(nlen_ff);
   end

endmodule

/* src/ctpd_emitter.sv */
// Result sequencer: status beat, then on success color and name beats read from the
// RAMs, through a registered output stage. Depends on ctpd_pkg and ctpd_if.
module ctpd_emitter #(
   parameter int ROLES = 14,
   parameter int MAX_NAME = 32,
   localparam int CA_W = (ROLES > 1) ? $clog2(ROLES) : 1,
   localparam int NA_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pkt_done,
   input  ctpd_pkg::summary_type summary,
   output ctpd_pkg::ctrl_type    ctrl,
   output logic                  color_rd_en,
   output logic [CA_W-1:0]       color_rd_addr,
   input  logic [23:0]           color_rd_data,
   output logic                  name_rd_en,
   output logic [NA_W-1:0]       name_rd_addr,
   input  logic [7:0]            name_rd_data,
   ctpd_rsp_if.source            rsp_bus
);
   import ctpd_pkg::*;

   localparam int ITEM_MAX = (ROLES > MAX_NAME) ? ROLES : MAX_NAME;
   localparam int ITEM_W = $clog2(ITEM_MAX + 1);

   emit_state_type state_ff, state_in;
   logic [ITEM_W-1:0] idx_ff, idx_in;
   logic slot_free, load, last_color, last_name, color_live;

   logic valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [2:0] status_ff, status_in;
   logic light_ff, light_in;
   logic [7:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [3:0] role_ff, role_in;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [7:0] char_ff, char_in;
   logic run_end_ff, run_end_in;

   assign slot_free = !valid_ff || rsp_bus.ready;
   assign last_color = idx_ff == ITEM_W'(ROLES - 1);
   assign last_name = name_len_type'(idx_ff) + name_len_type'(1) == summary.name_length;
   assign color_live = 8'(idx_ff) < summary.color_count;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      case (state_ff)
         EM_IDLE: begin
            if (pkt_done) begin
               state_in = EM_FIN;
            end
         end
         EM_FIN: begin
            if (slot_free) begin
               idx_in = '0;
               state_in = (summary.status == ST_OK) ? EM_COLOR_RD : EM_IDLE;
            end
         end
         EM_COLOR_RD: state_in = EM_COLOR_OUT;
         EM_COLOR_OUT: begin
            if (slot_free) begin
               if (last_color) begin
                  idx_in = '0;
                  state_in = (summary.name_length == '0) ? EM_IDLE : EM_NAME_RD;
               end else begin
                  idx_in = idx_ff + ITEM_W'(1);
                  state_in = EM_COLOR_RD;
               end
            end
         end
         EM_NAME_RD: state_in = EM_NAME_OUT;
         EM_NAME_OUT: begin
            if (slot_free) begin
               if (last_name) begin
                  state_in = EM_IDLE;
               end else begin
                  idx_in = idx_ff + ITEM_W'(1);
                  state_in = EM_NAME_RD;
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_comb begin
      ctrl.hold = state_ff != EM_IDLE;
      ctrl.clear = (state_ff != EM_IDLE) && (state_in == EM_IDLE);
      color_rd_en = state_ff == EM_COLOR_RD;
      name_rd_en = state_ff == EM_NAME_RD;
      load = slot_free && ((state_ff == EM_FIN) || (state_ff == EM_COLOR_OUT)
                           || (state_ff == EM_NAME_OUT));
      valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : valid_ff);
      kind_in = kind_ff;
      status_in = status_ff;
      light_in = light_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      role_in = role_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      char_in = char_ff;
      run_end_in = run_end_ff;
      if (load) begin
         kind_in = KIND_STATUS;
         status_in = ST_OK;
         light_in = 1'b0;
         count_in = 8'd0;
         crc_in = 16'd0;
         role_in = 4'd0;
         red_in = 8'd0;
         green_in = 8'd0;
         blue_in = 8'd0;
         char_in = 8'd0;
         run_end_in = 1'b0;
         case (state_ff)
            EM_FIN: begin
               status_in = summary.status;
               light_in = summary.light;
               count_in = summary.color_count;
               crc_in = summary.packet_crc;
               run_end_in = summary.status != ST_OK;
            end
            EM_COLOR_OUT: begin
               kind_in = KIND_COLOR;
               role_in = 4'(idx_ff);
               if (color_live) begin
                  red_in = color_rd_data[23:16];
                  green_in = color_rd_data[15:8];
                  blue_in = color_rd_data[7:0];
               end
               run_end_in = last_color && (summary.name_length == '0);
            end
            default: begin
               kind_in = KIND_NAME;
               char_in = name_rd_data;
               run_end_in = last_name;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      status_ff <= status_in;
      light_ff <= light_in;
      count_ff <= count_in;
      crc_ff <= crc_in;
      role_ff <= role_in;
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      char_ff <= char_in;
      run_end_ff <= run_end_in;
      if (reset) begin
         state_ff <= EM_IDLE;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign color_rd_addr = CA_W'(idx_ff);
   assign name_rd_addr = NA_W'(idx_ff);

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.kind = kind_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.light = light_ff;
   assign rsp_bus.color_count = count_ff;
   assign rsp_bus.packet_crc = crc_ff;
   assign rsp_bus.role = role_ff;
   assign rsp_bus.red = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue = blue_ff;
   assign rsp_bus.name_char = char_ff;
   assign rsp_bus.run_end = run_end_ff;

endmodule

/* src/color_table_packet_decoder.sv */
// Top level of the color table packet decoder: parser, result sequencer and
// the color and name RAMs. Depends on ctpd_pkg, ctpd_if, ctpd_ram,
// ctpd_parser and ctpd_emitter.
//
// Packet bytes enter on req_bus, one beat per cycle while ready is high, with
// end_of_packet on the final beat; the last two bytes are the little-endian
// CRC. Registers are to be written through csr_we/csr_index/csr_wdata only
// while no packet is in flight; the block does not enforce this. After the
// final beat, input is held off while rsp_bus carries a status beat and, on
// success, one beat per color role and one per stored name byte; each color
// or name beat is read from its RAM (registered read) in a RD state and loaded
// in an OUT state. A failed packet holds input only in EM_FIN; a good one also
// in the color and name states and while the receiver stalls. The output
// register holds a beat until it is taken, so input resumes while the final
// beat of a run still waits. Reset is synchronous: it restores the register
// defaults and the per-packet state; no RAM clearing pass is needed.
module color_table_packet_decoder #(
   parameter int MAX_PACKET = 256,
   parameter int HEADER_BYTES = 5,
   parameter int ROLES = 14,
   parameter int MAX_NAME = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  ctpd_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wdata,
   ctpd_req_if.sink                req_bus,
   ctpd_rsp_if.source              rsp_bus
);
   import ctpd_pkg::*;

   localparam int CA_W = (ROLES > 1) ? $clog2(ROLES) : 1;
   localparam int NA_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

   ctrl_type ctrl;
   summary_type summary;
   logic pkt_done;
   logic color_wr_en, color_rd_en, name_wr_en, name_rd_en;
   logic [CA_W-1:0] color_wr_addr, color_rd_addr;
   logic [NA_W-1:0] name_wr_addr, name_rd_addr;
   logic [23:0] color_wr_data, color_rd_data;
   logic [7:0] name_wr_data, name_rd_data;

   ctpd_parser #(
      .MAX_PACKET(MAX_PACKET),
      .HEADER_BYTES(HEADER_BYTES),
      .ROLES(ROLES),
      .MAX_NAME(MAX_NAME)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus(req_bus),
      .ctrl(ctrl),
      .pkt_done(pkt_done),
      .summary(summary),
      .color_wr_en(color_wr_en),
      .color_wr_addr(color_wr_addr),
      .color_wr_data(color_wr_data),
      .name_wr_en(name_wr_en),
      .name_wr_addr(name_wr_addr),
      .name_wr_data(name_wr_data)
   );

   ctpd_ram #(.WIDTH(24), .DEPTH(ROLES)) u_color_ram (
      .clock(clock),
      .wr_en(color_wr_en),
      .wr_addr(color_wr_addr),
      .wr_data(color_wr_data),
      .rd_en(color_rd_en),
      .rd_addr(color_rd_addr),
      .rd_data(color_rd_data)
   );

   ctpd_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name_ram (
      .clock(clock),
      .wr_en(name_wr_en),
      .wr_addr(name_wr_addr),
      .wr_data(name_wr_data),
      .rd_en(name_rd_en),
      .rd_addr(name_rd_addr),
      .rd_data(name_rd_data)
   );

   ctpd_emitter #(
      .ROLES(ROLES),
      .MAX_NAME(MAX_NAME)
   ) u_emitter (
      .clock(clock),
      .reset(reset),
      .pkt_done(pkt_done),
      .summary(summary),
      .ctrl(ctrl),
      .color_rd_en(color_rd_en),
      .color_rd_addr(color_rd_addr),
      .color_rd_data(color_rd_data),
      .name_rd_en(name_rd_en),
      .name_rd_addr(name_rd_addr),
      .name_rd_data(name_rd_data),
      .rsp_bus(rsp_bus)
   );

   a_hold_after_last: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.end_of_packet |=> !req_bus.ready)
      else $error("input not held off after the final beat");

   a_error_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == KIND_STATUS && rsp_bus.status != ST_OK
      |-> rsp_bus.run_end)
      else $error("error status beat does not end the run");

   a_role_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == KIND_COLOR |-> 32'(rsp_bus.role) < ROLES)
      else $error("color beat role out of range");

   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      (color_rd_en || name_rd_en) |-> !(color_wr_en || name_wr_en))
      else $error("RAM written while results are being read");

endmodule

/* test/ctpd_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the color table packet decoder: watches the register port and both
// channels, predicts every result beat and compares it with what the block sends.
// Depends on ctpd_pkg and the channel interfaces in ctpd_if.
module ctpd_result_checker #(
   parameter int MAX_PACKET = 256,
   parameter int HEADER_BYTES = 5,
   parameter int ROLES = 14,
   parameter int MAX_NAME = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  ctpd_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wdata,
   ctpd_req_if                     req_mon,
   ctpd_rsp_if                     rsp_mon,
   output int                      mismatch_count,
   output int                      pending_results
);
   import ctpd_pkg::*;

   localparam logic [15:0] CCITT_POLY = 16'h1021;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic        light;
      logic [7:0]  color_count;
      logic [15:0] packet_crc;
      logic [3:0]  role;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  name_char;
      logic        run_end;
   } decoded_beat_t;

   decoded_beat_t expected_beats[$];
   int fail_tally = 0;
   int beats_seen = 0;

   logic [7:0] magic0_reg, magic1_reg, version_reg, light_mask_reg, name_tag_reg;

   logic [7:0]      delay_q [2];
   int              delay_cnt;
   int              body_pos;
   logic [15:0]     crc_acc;
   logic            magic_err, version_err, light_flag;
   logic [7:0]      color_decl;
   logic [23:0]     palette [ROLES];
   logic [ROLES-1:0] palette_valid;
   phase_type       tlv_phase;
   logic            tlv_is_name;
   logic [7:0]      tlv_left;
   logic [7:0]      name_buf [MAX_NAME];
   int              name_len, name_wr;

   function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = acc[15] ^ d[i];
         acc = {acc[14:0], 1'b0};
         if (fb) acc = acc ^ CCITT_POLY;
      end
      return acc;
   endfunction

   function automatic string beat_text(decoded_beat_t t);
      return $sformatf("kind=%0d status=%0d light=%0d count=%0d crc=%04h role=%0d rgb=%02h%02h%02h char=%02h end=%0d",
                       t.kind, t.status, t.light, t.color_count, t.packet_crc, t.role,
                       t.red, t.green, t.blue, t.name_char, t.run_end);
   endfunction

   task automatic clear_frame_state();
      delay_q[0] = '0;
      delay_q[1] = '0;
      delay_cnt = 0;
      body_pos = 0;
      crc_acc = CRC_INIT;
      magic_err = 1'b0;
      version_err = 1'b0;
      light_flag = 1'b0;
      color_decl = '0;
      palette_valid = '0;
      tlv_phase = PH_TAG;
      tlv_is_name = 1'b0;
      tlv_left = '0;
      name_len = 0;
      name_wr = 0;
   endtask

   task automatic take_body_byte(input logic [7:0] b);
      int p, off, idx, colors_limit;
      p = body_pos;
      if (p >= MAX_PACKET) return;
      body_pos = p + 1;
      crc_acc = crc_step(crc_acc, b);
      case (p)
         POS_MAGIC0:  magic_err = magic_err | (b != magic0_reg);
         POS_MAGIC1:  magic_err = magic_err | (b != magic1_reg);
         POS_VERSION: version_err = (b != version_reg);
         POS_FLAGS:   light_flag = ((b & light_mask_reg) != 8'h00);
         POS_COUNT:   color_decl = b;
         default: ;
      endcase
      if (p < HEADER_BYTES) return;
      colors_limit = HEADER_BYTES + 3 * int'(color_decl);
      if (p < colors_limit) begin
         off = p - HEADER_BYTES;
         idx = off / 3;
         if (idx < ROLES) begin
            case (off % 3)
               0: palette[idx][23:16] = b;
               1: palette[idx][15:8] = b;
               default: palette[idx][7:0] = b;
            endcase
            palette_valid[idx] = 1'b1;
         end
         return;
      end
      case (tlv_phase)
         PH_TAG: begin
            tlv_is_name = (b == name_tag_reg);
            tlv_phase = PH_LEN;
         end
         PH_LEN: begin
            if (tlv_is_name) begin
               name_len = 0;
               name_wr = 0;
            end
            tlv_left = b;
            tlv_phase = (b == 8'h00) ? PH_TAG : PH_VALUE;
         end
         default: begin
            if (tlv_is_name) begin
               if (name_wr < MAX_NAME) begin
                  name_buf[name_wr] = b;
                  name_len = name_wr + 1;
               end
               if (name_wr < 255) name_wr++;
            end
            tlv_left = tlv_left - 8'd1;
            if (tlv_left == 8'h00) tlv_phase = PH_TAG;
         end
      endcase
   endtask

   task automatic predict_beat(input logic [7:0] b, input logic eop);
      decoded_beat_t item;
      logic [2:0] code;
      logic [15:0] crc_rx;
      int total;
      if (delay_cnt >= 2) begin
         take_body_byte(delay_q[0]);
         delay_q[0] = delay_q[1];
         delay_q[1] = b;
      end else begin
         delay_q[delay_cnt] = b;
         delay_cnt++;
      end
      if (!eop) return;

      total = body_pos + delay_cnt;
      crc_rx = {delay_q[1], delay_q[0]};
      if (delay_cnt < 2 || total > MAX_PACKET || body_pos < HEADER_BYTES) code = ST_TRUNCATED;
      else if (magic_err) code = ST_BAD_MAGIC;
      else if (version_err) code = ST_BAD_VERSION;
      else if (crc_acc != crc_rx) code = ST_BAD_CRC;
      else if (HEADER_BYTES + 3 * int'(color_decl) > body_pos) code = ST_TRUNCATED;
      else if (tlv_phase != PH_TAG) code = ST_BAD_TLV;
      else code = ST_OK;

      item = '0;
      item.kind = KIND_STATUS;
      item.status = code;
      if (code == ST_OK) begin
         item.light = light_flag;
         item.color_count = color_decl;
         item.packet_crc = crc_rx;
      end
      expected_beats.push_back(item);
      if (code == ST_OK) begin
         for (int i = 0; i < ROLES; i++) begin
            item = '0;
            item.kind = KIND_COLOR;
            item.role = 4'(i);
            if (palette_valid[i]) {item.red, item.green, item.blue} = palette[i];
            expected_beats.push_back(item);
         end
         for (int i = 0; i < name_len; i++) begin
            item = '0;
            item.kind = KIND_NAME;
            item.name_char = name_buf[i];
            expected_beats.push_back(item);
         end
      end
      expected_beats[expected_beats.size() - 1].run_end = 1'b1;
      clear_frame_state();
   endtask

   always @(posedge clock) begin
      decoded_beat_t seen, want;
      if (reset) begin
         magic0_reg = 8'h00;
         magic1_reg = 8'h00;
         version_reg = 8'h01;
         light_mask_reg = 8'h01;
         name_tag_reg = 8'h01;
         foreach (palette[i]) palette[i] = '0;
         clear_frame_state();
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MAGIC_FIRST:   magic0_reg = csr_wdata;
               REG_MAGIC_SECOND:  magic1_reg = csr_wdata;
               REG_PROTO_VERSION: version_reg = csr_wdata;
               REG_LIGHT_MASK:    light_mask_reg = csr_wdata;
               REG_NAME_TAG:      name_tag_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_beat(req_mon.data_byte, req_mon.end_of_packet);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.kind, rsp_mon.status, rsp_mon.light, rsp_mon.color_count,
                    rsp_mon.packet_crc, rsp_mon.role, rsp_mon.red, rsp_mon.green,
                    rsp_mon.blue, rsp_mon.name_char, rsp_mon.run_end};
            if (expected_beats.size() == 0) begin
               if (fail_tally < 10)
                  $display("beat %0d arrived with nothing expected: %s",
                           beats_seen, beat_text(seen));
               fail_tally++;
            end else begin
               want = expected_beats.pop_front();
               if (seen !== want) begin
                  if (fail_tally < 10) begin
                     $display("beat %0d expected %s", beats_seen, beat_text(want));
                     $display("beat %0d actual   %s", beats_seen, beat_text(seen));
                  end
                  fail_tally++;
               end
            end
            beats_seen++;
         end
      end
      mismatch_count <= fail_tally;
      pending_results <= expected_beats.size();
   end

endmodule

/* test/color_table_packet_decoder_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the color table packet decoder: builds packets, drives the byte channel,
// stalls the result channel and gives the verdict. Depends on ctpd_pkg, ctpd_if, the
// decoder and ctpd_result_checker.
module color_table_packet_decoder_tb;
   import ctpd_pkg::*;

   localparam int MAX_PACKET = 256;
   localparam int HEADER_BYTES = 5;
   localparam int ROLES = 14;
   localparam int MAX_NAME = 32;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int PHASE_BYTES = 60;
   localparam int TIMEOUT_NS = 2_000_000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = REG_MAGIC_FIRST;
   logic [7:0]    csr_wdata = 8'h00;

   int mismatches;
   int results_pending;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit rx_hold_req = 1'b0;

   logic [7:0] cfg_magic0 = 8'h00;
   logic [7:0] cfg_magic1 = 8'h00;
   logic [7:0] cfg_version = 8'h01;
   logic [7:0] cfg_light = 8'h01;
   logic [7:0] cfg_tag = 8'h01;

   logic [7:0] frame[$];

   ctpd_req_if req_bus();
   ctpd_rsp_if rsp_bus();

   color_table_packet_decoder #(
      .MAX_PACKET(MAX_PACKET),
      .HEADER_BYTES(HEADER_BYTES),
      .ROLES(ROLES),
      .MAX_NAME(MAX_NAME)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   ctpd_result_checker #(
      .MAX_PACKET(MAX_PACKET),
      .HEADER_BYTES(HEADER_BYTES),
      .ROLES(ROLES),
      .MAX_NAME(MAX_NAME)
   ) decode_check (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .mismatch_count(mismatches),
      .pending_results(results_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("color_table_packet_decoder: mismatch");
      $finish;
   end

   // The receiver can be held off for a long stretch so that the decoder fills up.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic program_regs(input logic [7:0] m0, input logic [7:0] m1,
                               input logic [7:0] ver, input logic [7:0] mask,
                               input logic [7:0] tag);
      csr_index_type regs [5] = '{REG_MAGIC_FIRST, REG_MAGIC_SECOND, REG_PROTO_VERSION,
                                  REG_LIGHT_MASK, REG_NAME_TAG};
      logic [7:0] vals [5];
      vals = '{m0, m1, ver, mask, tag};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_magic0 = m0;
      cfg_magic1 = m1;
      cfg_version = ver;
      cfg_light = mask;
      cfg_tag = tag;
   endtask

   task automatic start_frame(input logic [7:0] flags, input logic [7:0] count);
      frame.delete();
      frame.push_back(cfg_magic0);
      frame.push_back(cfg_magic1);
      frame.push_back(cfg_version);
      frame.push_back(flags);
      frame.push_back(count);
   endtask

   task automatic add_colors(input int n);
      repeat (3 * n) frame.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_record(input logic [7:0] tag, input int len);
      frame.push_back(tag);
      frame.push_back(8'(len));
      repeat (len) frame.push_back(8'($urandom_range(255)));
   endtask

   task automatic seal_frame(input logic [15:0] flip);
      logic [15:0] acc;
      acc = CRC_INIT;
      foreach (frame[i]) acc = crc16_byte(acc, frame[i]);
      acc = acc ^ flip;
      frame.push_back(acc[7:0]);
      frame.push_back(acc[15:8]);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.data_byte <= frame[i];
         req_bus.end_of_packet <= (i == frame.size() - 1);
         do @(posedge clock); while (!req_bus.ready);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_frame(input bit clean);
      int sel, n, len;
      logic [7:0] tag;
      sel = clean ? 99 : $urandom_range(99);
      if (sel < 8) begin
         frame.delete();
         repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(255)));
         return;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
      start_frame(8'($urandom_range(255)), 8'(n));
      add_colors(n);
      repeat ($urandom_range(0, 3)) begin
         tag = $urandom_range(1) ? cfg_tag : 8'($urandom_range(255));
         len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
         add_record(tag, len);
      end
      if (sel < 14) begin
         frame[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end else if (sel < 19) begin
         frame[POS_VERSION] ^= 8'($urandom_range(1, 255));
      end else if (sel < 24) begin
         frame[POS_COUNT] = 8'($urandom_range(n + 1, 255));
      end else if (sel < 30) begin
         frame.push_back(8'($urandom_range(255)));
         if ($urandom_range(1)) begin
            frame.push_back(8'($urandom_range(2, 9)));
            frame.push_back(8'($urandom_range(255)));
         end
      end else if (sel < 34) begin
         repeat ($urandom_range(1, 3)) if (frame.size() > 1) void'(frame.pop_back());
      end
      seal_frame((sel >= 34 && sel < 40) ? 16'(1 << $urandom_range(15)) : 16'h0000);
   endtask

   task automatic random_phase();
      int sent;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         random_frame(1'b0);
         send_frame();
         sent += frame.size();
         if ($urandom_range(7) == 0) drain();
      end
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.end_of_packet = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed packets under the reset register values.
      start_frame(8'h00, 8'h00);
      seal_frame(16'h0000);
      send_frame();

      // Extreme colors, a name holding a zero byte, and a record of another tag.
      start_frame(8'hFF, 8'h02);
      frame.push_back(8'h00); frame.push_back(8'h00); frame.push_back(8'h00);
      frame.push_back(8'hFF); frame.push_back(8'hFF); frame.push_back(8'hFF);
      frame.push_back(cfg_tag); frame.push_back(8'h03);
      frame.push_back(8'h41); frame.push_back(8'h00); frame.push_back(8'hFF);
      add_record(8'h07, 2);
      seal_frame(16'h0000);
      send_frame();

      // More colors than roles, and a later name longer than the name store.
      start_frame(8'h01, 8'd16);
      add_colors(16);
      add_record(cfg_tag, 5);
      add_record(cfg_tag, 40);
      seal_frame(16'h0000);
      send_frame();

      // A zero-length name record clears the name.
      start_frame(8'hFE, 8'h01);
      add_colors(1);
      add_record(cfg_tag, 4);
      add_record(cfg_tag, 0);
      seal_frame(16'h0000);
      send_frame();

      // Largest packet that fits, then one byte more.
      start_frame(8'h00, 8'h00);
      add_record(cfg_tag, 247);
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h00);
      add_record(cfg_tag, 248);
      seal_frame(16'h0000);
      send_frame();

      // Packets too short to hold a header and its CRC.
      frame.delete();
      frame.push_back(8'hA5);
      send_frame();
      start_frame(8'h00, 8'h00);
      frame.push_back(8'h00);
      send_frame();

      // Each error in turn.
      start_frame(8'h00, 8'h00);
      frame[POS_MAGIC0] ^= 8'h80;
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h00);
      frame[POS_MAGIC1] ^= 8'h01;
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h00);
      frame[POS_VERSION] ^= 8'hFF;
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h00);
      seal_frame(16'h0001);
      send_frame();
      start_frame(8'h00, 8'h00);
      seal_frame(16'h8000);
      send_frame();
      start_frame(8'h00, 8'hFF);
      add_colors(2);
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h00);
      frame.push_back(8'h09);
      seal_frame(16'h0000);
      send_frame();
      start_frame(8'h00, 8'h01);
      add_colors(1);
      frame.push_back(cfg_tag); frame.push_back(8'h05);
      frame.push_back(8'h01); frame.push_back(8'h02);
      seal_frame(16'h0000);
      send_frame();

      // Several errors at once; magic wins.
      start_frame(8'h00, 8'h00);
      frame[POS_MAGIC0] ^= 8'h01;
      frame[POS_VERSION] ^= 8'h01;
      seal_frame(16'h1234);
      send_frame();
      drain();

      program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      tx_idle_pct = 32;
      rx_idle_pct = 60;
      rx_hold_req = 1'b1;
      repeat (4) begin
         random_frame(1'b1);
         send_frame();
      end
      drain();
      random_phase();

      program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      tx_idle_pct = 60;
      rx_idle_pct = 32;
      random_phase();

      program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase();

      repeat (16) @(posedge clock);
      if (mismatches == 0 && results_pending == 0)
         $display("color_table_packet_decoder: match");
      else
         $display("color_table_packet_decoder: mismatch");
      $finish;
   end

endmodule
